// ----- hdl/modular_exponentiation_assert.svh -----
// Assertion macros shared by the modular exponentiation RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ME_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/me_pkg.sv -----
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps

package me_pkg;

  localparam int FIELD_W      = 32;
  localparam int OPERAND_BITS = 32;
  localparam int CNT_W        = $clog2(OPERAND_BITS);

  typedef logic [FIELD_W-1:0]      field_t;
  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [CNT_W-1:0]        bit_cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_FINISH
  } state_t;

  // sequencer -> modular multiplier
  typedef struct packed {
    logic     start;
    operand_t a;
    operand_t b;
  } mm_cmd_t;

  // modular multiplier -> sequencer
  typedef struct packed {
    logic     done;
    operand_t product;
  } mm_stat_t;

endpackage

// ----- hdl/me_if.sv -----
// Handshake channel interfaces for the modular exponentiation block.
// Depends on me_pkg.
`timescale 1ns / 1ps

interface me_in_if;
  logic            valid;
  logic            ready;
  me_pkg::field_t  base;
  me_pkg::field_t  power;
  modport source (output valid, base, power, input ready);
  modport sink   (input valid, base, power, output ready);
endinterface

interface me_out_if;
  logic            valid;
  logic            ready;
  me_pkg::field_t  residue;
  modport source (output valid, residue, input ready);
  modport sink   (input valid, residue, output ready);
endinterface

interface me_cfg_if;
  logic            valid;
  logic            ready;
  me_pkg::field_t  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/me_mul.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on me_pkg and modular_exponentiation_assert.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module me_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  me_pkg::operand_t  modulus_i,
  input  me_pkg::mm_cmd_t   cmd_i,
  output me_pkg::mm_stat_t  stat_o
);

  localparam int W = me_pkg::OPERAND_BITS;
  localparam me_pkg::bit_cnt_t LAST = me_pkg::CNT_W'(W - 1);

  logic             busy_r;
  logic             done_r;
  me_pkg::bit_cnt_t cnt_r;
  me_pkg::operand_t acc_r;
  me_pkg::operand_t mcand_r;
  me_pkg::operand_t mplier_r;

  logic [W:0]       dbl;
  logic [W+1:0]     dbl_add;
  logic [W:0]       n1;
  logic [W+1:0]     n1_w;
  logic [W+1:0]     n2_w;
  me_pkg::operand_t acc_nxt;

  // acc <- 2*acc (+ a) mod n, all candidates formed side by side
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_add = {1'b0, dbl} + {2'b00, mcand_r};
    n1      = {1'b0, modulus_i};
    n1_w    = {2'b00, modulus_i};
    n2_w    = {1'b0, modulus_i, 1'b0};
    if (!mplier_r[W-1]) begin
      acc_nxt = (dbl >= n1) ? W'(dbl - n1) : W'(dbl);
    end else if (dbl >= n1) begin
      acc_nxt = (dbl_add >= n2_w) ? W'(dbl_add - n2_w) : W'(dbl_add - n1_w);
    end else begin
      acc_nxt = (dbl_add >= n1_w) ? W'(dbl_add - n1_w) : W'(dbl_add);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      acc_r    <= '0;
      mcand_r  <= cmd_i.a;
      mplier_r <= cmd_i.b;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mplier_r <= {mplier_r[W-2:0], 1'b0};
    end
  end

  assign stat_o.done    = done_r;
  assign stat_o.product = acc_r;

  `ME_ASSERT_SAME(a_no_restart, cmd_i.start, !busy_r, "multiply started while busy")
  `ME_ASSERT_NEXT(a_done_after_last, busy_r && !cmd_i.start && (cnt_r == LAST),
                  done_r && !busy_r, "multiply did not finish after last bit")
  `ME_ASSERT_SAME(a_product_reduced, done_r, acc_r < modulus_i, "product not reduced")

endmodule

// ----- hdl/me_ctrl.sv -----
// Square-and-multiply sequencer with operand, exponent and result registers.
// Depends on me_pkg, me_if, modular_exponentiation_assert.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module me_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  me_in_if.sink             in_if,
  me_out_if.source          out_if,
  input  me_pkg::operand_t  modulus_i,
  output me_pkg::mm_cmd_t   cmd_o,
  input  me_pkg::mm_stat_t  stat_i
);

  localparam int W = me_pkg::OPERAND_BITS;
  localparam me_pkg::bit_cnt_t LAST = me_pkg::CNT_W'(W - 1);

  me_pkg::state_t   state_r;
  me_pkg::state_t   state_nxt;
  me_pkg::operand_t base_r;
  me_pkg::operand_t exp_r;
  me_pkg::operand_t x_r;
  me_pkg::operand_t acc_r;
  me_pkg::bit_cnt_t bit_cnt_r;
  logic             out_valid_r;
  me_pkg::field_t   residue_r;

  logic             accept;
  logic             out_load;
  logic             last_bit;
  me_pkg::operand_t one;

  assign accept   = in_if.valid && in_if.ready;
  assign last_bit = (bit_cnt_r == LAST);
  // 1 mod n
  assign one      = (modulus_i == me_pkg::operand_t'(1)) ? '0 : me_pkg::operand_t'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      me_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = (modulus_i == '0) ? me_pkg::ST_FINISH : me_pkg::ST_RED_GO;
        end
      end
      me_pkg::ST_RED_GO: state_nxt = me_pkg::ST_RED_WAIT;
      me_pkg::ST_RED_WAIT: begin
        if (stat_i.done) state_nxt = me_pkg::ST_SQ_GO;
      end
      me_pkg::ST_SQ_GO: state_nxt = me_pkg::ST_SQ_WAIT;
      me_pkg::ST_SQ_WAIT: begin
        if (stat_i.done) begin
          if (exp_r[W-1])    state_nxt = me_pkg::ST_MUL_GO;
          else if (last_bit) state_nxt = me_pkg::ST_FINISH;
          else               state_nxt = me_pkg::ST_SQ_GO;
        end
      end
      me_pkg::ST_MUL_GO: state_nxt = me_pkg::ST_MUL_WAIT;
      me_pkg::ST_MUL_WAIT: begin
        if (stat_i.done) state_nxt = last_bit ? me_pkg::ST_FINISH : me_pkg::ST_SQ_GO;
      end
      me_pkg::ST_FINISH: begin
        if (!out_valid_r || out_if.ready) state_nxt = me_pkg::ST_IDLE;
      end
      default: state_nxt = me_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    out_load    = 1'b0;
    cmd_o.start = 1'b0;
    cmd_o.a     = acc_r;
    cmd_o.b     = acc_r;
    case (state_r)
      me_pkg::ST_IDLE:   in_if.ready = 1'b1;
      // base mod n is formed as (1 mod n) * base
      me_pkg::ST_RED_GO: begin
        cmd_o.start = 1'b1;
        cmd_o.a     = one;
        cmd_o.b     = base_r;
      end
      me_pkg::ST_SQ_GO:  cmd_o.start = 1'b1;
      me_pkg::ST_MUL_GO: begin
        cmd_o.start = 1'b1;
        cmd_o.b     = x_r;
      end
      me_pkg::ST_FINISH: out_load = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= me_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_r    <= me_pkg::operand_t'(in_if.base);
      exp_r     <= me_pkg::operand_t'(in_if.power);
      acc_r     <= '0;
      bit_cnt_r <= '0;
    end
    if (stat_i.done) begin
      case (state_r)
        me_pkg::ST_RED_WAIT: begin
          x_r   <= stat_i.product;
          acc_r <= one;
        end
        me_pkg::ST_SQ_WAIT: begin
          acc_r <= stat_i.product;
          if (!exp_r[W-1]) begin
            exp_r     <= {exp_r[W-2:0], 1'b0};
            bit_cnt_r <= bit_cnt_r + 1'b1;
          end
        end
        me_pkg::ST_MUL_WAIT: begin
          acc_r     <= stat_i.product;
          exp_r     <= {exp_r[W-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + 1'b1;
        end
        default: ;
      endcase
    end
    if (out_load) residue_r <= me_pkg::FIELD_W'(acc_r);
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.residue = residue_r;

  `ME_ASSERT_NEXT(a_busy_after_request, accept, state_r != me_pkg::ST_IDLE,
                  "request accepted but sequencer stayed idle")
  `ME_ASSERT_SAME(a_done_when_waiting, stat_i.done,
                  (state_r == me_pkg::ST_RED_WAIT) || (state_r == me_pkg::ST_SQ_WAIT) ||
                  (state_r == me_pkg::ST_MUL_WAIT), "multiply finished outside a wait state")
  `ME_ASSERT_SAME(a_result_reduced, (state_r == me_pkg::ST_FINISH) && (modulus_i != '0),
                  acc_r < modulus_i, "result not reduced")

endmodule

// ----- hdl/modular_exponentiation.sv -----
// Modular exponentiation: residue = base ^ power mod modulus, left-to-right binary.
// Result offered once the request is taken and the operands have passed the bit-serial
// multiplier: a reduction of base, a squaring per bit of power and a multiply per one.
// One request at a time, a new one taken only in idle once the last has finished;
// the next is taken while the last result waits at the output.
// Reset (rst_n low, synchronous) clears control state and sets the modulus to 1.
`timescale 1ns / 1ps

module modular_exponentiation (
  input  logic      clk,
  input  logic      rst_n,
  me_in_if.sink     in_if,
  me_out_if.source  out_if,
  me_cfg_if.sink    cfg_if
);

  me_pkg::field_t   modulus_r;
  me_pkg::mm_cmd_t  mm_cmd;
  me_pkg::mm_stat_t mm_stat;
  me_pkg::operand_t modulus_op;

  assign cfg_if.ready = 1'b1;
  assign modulus_op   = me_pkg::OPERAND_BITS'(modulus_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= me_pkg::FIELD_W'(1);
    end else if (cfg_if.valid) begin
      modulus_r <= cfg_if.data;
    end
  end

  me_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .modulus_i (modulus_op),
    .cmd_o     (mm_cmd),
    .stat_i    (mm_stat)
  );

  me_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .modulus_i (modulus_op),
    .cmd_i     (mm_cmd),
    .stat_o    (mm_stat)
  );

endmodule

// ----- tb/tb_modular_exponentiation.sv -----
// Self-checking testbench for modular_exponentiation: drives requests, predicts each residue
// with 64-bit square-and-multiply and compares every result in order of arrival.
// Depends on me_pkg and the handshake interfaces in me_if.sv.
`timescale 1ns / 1ps

module tb_modular_exponentiation;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL_CYCLES = 2500;

  logic clk = 1'b0;
  logic rst_n;

  me_in_if  in_if();
  me_out_if out_if();
  me_cfg_if cfg_if();

  modular_exponentiation DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #5 clk = ~clk;

  me_pkg::field_t expected_residues[$];
  me_pkg::field_t modulus_now = 32'd1;
  int             error_count = 0;
  int             cycle_count = 0;
  bit             idle_en     = 1'b1;
  int             hold_cycles = 0;

  // base ^ power mod n; 64-bit products keep every step exact for 32-bit operands
  function automatic me_pkg::field_t predict_residue(me_pkg::field_t b, me_pkg::field_t p,
                                                     me_pkg::field_t n);
    me_pkg::operand_t b_op;
    me_pkg::operand_t p_op;
    me_pkg::operand_t n_op;
    longint unsigned  acc;
    longint unsigned  x;
    longint unsigned  m;
    b_op = me_pkg::operand_t'(b);
    p_op = me_pkg::operand_t'(p);
    n_op = me_pkg::operand_t'(n);
    if (n_op == '0) return '0;
    m   = n_op;
    acc = 1 % m;
    x   = b_op % m;
    for (int i = me_pkg::OPERAND_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (p_op[i]) acc = (acc * x) % m;
    end
    return me_pkg::field_t'(acc);
  endfunction

  function automatic me_pkg::field_t pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return me_pkg::field_t'($urandom_range(0, 15));
      3: return ~me_pkg::field_t'($urandom_range(0, 15));
      default: return me_pkg::field_t'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(string what, me_pkg::field_t got, me_pkg::field_t want);
    if (error_count < 40)
      $display("[%0t] mismatch: %s got %08h want %08h", $time, what, got, want);
    error_count++;
  endtask

  // Only issued with nothing in flight, so the predictor's copy stays in step
  task automatic write_modulus(me_pkg::field_t n);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= n;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    modulus_now = n;
  endtask

  // valid is left high; a gap or a drain lowers it in a later step
  task automatic send_request(me_pkg::field_t b, me_pkg::field_t p);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.base  <= b;
    in_if.power <= p;
    do @(posedge clk); while (!in_if.ready);
    expected_residues.push_back(predict_residue(b, p, modulus_now));
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_residues.size() != 0) @(posedge clk);
  endtask

  // Result sink: random stalls, or a long counted hold-off when asked
  initial begin : result_sink
    int n;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid && out_if.ready) begin
      if (expected_residues.size() == 0)
        report_mismatch("unexpected result", out_if.residue, '0);
      else begin
        me_pkg::field_t want;
        want = expected_residues.pop_front();
        if (out_if.residue !== want) report_mismatch("residue", out_if.residue, want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reset value of the modulus is 1, so every residue is zero
  task automatic test_reset_modulus();
    send_request(32'd5, 32'd3);
    send_request(32'd0, 32'd0);
    wait_drain();
  endtask

  task automatic test_zero_modulus();
    write_modulus(32'd0);
    send_request(32'd7, 32'd9);
    send_request(32'd0, 32'd0);
    wait_drain();
  endtask

  task automatic test_field_extremes();
    write_modulus(32'hFFFF_FFFF);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'h0000_0001);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'hFFFF_FFFF);
    send_request(32'h0000_0002, 32'd31);
    send_request(32'h0000_0002, 32'd32);
    send_request(32'hFFFF_FFFE, 32'h0000_0002);
    send_request(32'h8000_0000, 32'h0000_0002);
    wait_drain();
    write_modulus(32'd2);
    send_request(32'd3, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drain();
  endtask

  // Textbook key pair n = 61 * 53, e = 17, d = 2753
  task automatic test_rsa_round_trip();
    write_modulus(32'd3233);
    send_request(32'd65, 32'd17);
    send_request(32'd2790, 32'd2753);
    send_request(32'd3233, 32'd5);
    send_request(32'd0, 32'd0);
    wait_drain();
  endtask

  task automatic test_random_phases();
    me_pkg::field_t moduli[6];
    moduli[0] = 32'd1;
    moduli[1] = me_pkg::field_t'($urandom());
    moduli[2] = 32'h8000_0000;
    moduli[3] = me_pkg::field_t'($urandom_range(3, 65535));
    moduli[4] = 32'hFFFF_FFFF;
    moduli[5] = me_pkg::field_t'($urandom()) | 32'h8000_0001;
    for (int ph = 0; ph < 6; ph++) begin
      idle_en = (ph % 3 != 2);
      write_modulus(moduli[ph]);
      repeat (35) send_request(pick_operand(), pick_operand());
      wait_drain();
    end
    idle_en = 1'b1;
  endtask

  // Sink holds off long enough that one result waits, a second is computed
  // and further requests stall at the input
  task automatic test_output_backpressure();
    write_modulus(me_pkg::field_t'($urandom()));
    hold_cycles = 8000;
    repeat (6) send_request(pick_operand(), pick_operand());
    wait_drain();
  endtask

  task automatic test_sender_pause();
    repeat (3) send_request(pick_operand(), pick_operand());
    wait_drain();
    repeat (3) send_request(pick_operand(), pick_operand());
    wait_drain();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    write_modulus(me_pkg::field_t'($urandom()));
    repeat (40) send_request(pick_operand(), pick_operand());
    wait_drain();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.base   <= '0;
    in_if.power  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_modulus();
    test_zero_modulus();
    test_field_extremes();
    test_rsa_round_trip();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();
    test_back_to_back();

    // catch any stray result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
